/* sv/mbro_pkg.sv */
// Shared types, constants and helpers for the mono bitmap raster-op block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mbro_pkg;

   localparam int DEF_MAX_ROW_BYTES = 64;
   localparam int DEF_MAX_ROWS      = 256;
   localparam int DEF_MAX_SEGMENT   = 64;

   localparam int MODE_W   = 3;
   localparam int POSX_W   = 10;
   localparam int POSY_W   = 8;
   localparam int SPAN_W   = 10;
   localparam int RB_REG_W = 7;
   localparam int IR_REG_W = 9;
   localparam int CSR_W    = 9;
   localparam int REQ_DATA_W = 48;

   localparam logic [MODE_W-1:0] MODE_PUT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GET  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_XOR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SEG  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FILL = 3'd4;

   localparam logic CSR_ROW_BYTES  = 1'b0;
   localparam logic CSR_IMAGE_ROWS = 1'b1;

   localparam logic [7:0] BYTE_MSB  = 8'h80;
   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // datapath operations requested by the controller
   typedef enum logic [2:0] {
      OP_NONE, OP_LOAD, OP_RD, OP_WR, OP_NEXT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic in_range;    // current address inside store
      logic job_done;    // no further byte/pixel to visit
      logic is_read;     // request yields pixels
      logic pix;         // pixel selected from read byte
      logic final_item;  // current pixel is last of request
   } sts_type;

endpackage

/* sv/mbro_datapath.sv */
// Datapath: request registers, address walker, byte store and pixel select.
// Depends on mbro_pkg.
`timescale 1ns / 1ps

module mbro_datapath
   import mbro_pkg::*;
#(
   parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int MAX_SEGMENT   = DEF_MAX_SEGMENT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_word,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_data,
   input  cmd_type               cmd,
   output sts_type               sts
);
   localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH + 1) + 1;
   localparam int CW    = $clog2(MAX_ROW_BYTES + 1) + 1;
   localparam int RW    = $clog2(MAX_ROWS + 1) + 1;
   localparam int SEGW  = $clog2(MAX_SEGMENT + 1);
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];

   logic [RB_REG_W-1:0] rb_reg_ff;
   logic [IR_REG_W-1:0] ir_reg_ff;
   logic [CW-1:0] rb;
   logic [RW-1:0] rows;

   logic [MODE_W-1:0] mode_ff;
   logic              color_ff;
   logic [CW-1:0]     ebyte_ff, col_ff, sbyte_ff;
   logic [7:0]        smask_ff, emask_ff;
   logic [RW-1:0]     rows_left_ff;
   logic [AW-1:0]     base_ff;
   logic [AW-1:0]     fill_end_ff;
   logic [POSX_W+SEGW-1:0] px_ff;
   logic [SEGW-1:0]   seg_left_ff;
   logic              done_ff;
   logic [7:0]        rdata_ff;
   logic [2:0]        bitsel_ff;
   logic              rd_valid_ff;

   logic [MODE_W-1:0] f_mode;
   logic [POSX_W-1:0] f_x;
   logic [POSY_W-1:0] f_y;
   logic [SPAN_W-1:0] f_w, f_h;
   logic              f_color;

   assign f_mode  = req_word[2:0];
   assign f_x     = req_word[12:3];
   assign f_y     = req_word[20:13];
   assign f_w     = req_word[30:21];
   assign f_h     = req_word[40:31];
   assign f_color = req_word[41];

   always_comb begin
      if (rb_reg_ff == '0) rb = CW'(1);
      else if (32'(rb_reg_ff) > MAX_ROW_BYTES) rb = CW'(MAX_ROW_BYTES);
      else rb = CW'(rb_reg_ff);
      if (ir_reg_ff == '0) rows = RW'(1);
      else if (32'(ir_reg_ff) > MAX_ROWS) rows = RW'(MAX_ROWS);
      else rows = RW'(ir_reg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_reg_ff <= RB_REG_W'(64);
         ir_reg_ff <= IR_REG_W'(256);
      end else if (csr_we) begin
         if (csr_index == CSR_ROW_BYTES) rb_reg_ff <= csr_data[RB_REG_W-1:0];
         else ir_reg_ff <= csr_data;
      end
   end

   // load-time values
   logic [POSX_W:0] xe;
   logic [CW-1:0]   l_sbyte, l_ebyte;
   logic [7:0]      l_smask, l_emask;
   logic            l_done;
   logic [RW-1:0]   l_nrows;
   logic [SEGW-1:0] l_n;
   logic [POSX_W-4:0] sb_raw;
   logic [POSX_W-3:0] eb_raw;

   always_comb begin
      xe      = {1'b0, f_x} + {1'b0, f_w};
      sb_raw  = f_x[POSX_W-1:3];
      eb_raw  = xe[POSX_W:3];
      l_smask = BYTE_ONES >> f_x[2:0];
      l_emask = ~(BYTE_ONES >> xe[2:0]);
      l_sbyte = CW'(sb_raw);
      l_ebyte = (32'(eb_raw) > 32'(rb)) ? rb : CW'(eb_raw);
      l_done  = 1'b0;
      l_nrows = '0;
      if (32'(f_w) > MAX_SEGMENT) l_n = SEGW'(MAX_SEGMENT);
      else l_n = SEGW'(f_w);
      if (f_mode == MODE_XOR) begin
         if (32'(sb_raw) >= 32'(rb) || 32'(f_y) >= 32'(rows)) l_done = 1'b1;
         else begin
            if ({1'b0, sb_raw} == eb_raw) begin
               l_smask = l_smask & l_emask;
               l_ebyte = l_sbyte;
            end else if (32'(eb_raw) >= 32'(rb)) begin
               l_emask = '0;
            end
            if (32'(f_h) + 32'(f_y) > 32'(rows)) l_nrows = RW'(32'(rows) - 32'(f_y));
            else l_nrows = RW'(f_h);
            if (l_nrows == '0) l_done = 1'b1;
         end
      end
   end

   // current address
   logic [AW-1:0] addr;
   logic [AW-1:0] seg_addr;
   always_comb begin
      seg_addr = AW'(32'(base_ff) + 32'(px_ff[POSX_W+SEGW-1:3]));
      case (mode_ff)
         MODE_XOR:  addr = AW'(32'(base_ff) + 32'(col_ff));
         MODE_FILL: addr = base_ff;
         default:   addr = seg_addr;
      endcase
   end

   logic [7:0] xmask;
   logic [7:0] bit_m;
   always_comb begin
      bit_m = BYTE_MSB >> px_ff[2:0];
      if (col_ff == sbyte_ff) xmask = smask_ff;
      else if (col_ff == ebyte_ff) xmask = emask_ff;
      else xmask = BYTE_ONES;
   end

   logic in_range;
   assign in_range = 32'(addr) < DEPTH;

   // store: one read or one write a cycle, read data registered
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RD && in_range) rdata_ff <= mem[addr[IW-1:0]];
      if (cmd.op == OP_WR && in_range) begin
         case (mode_ff)
            MODE_PUT:  mem[addr[IW-1:0]] <= color_ff ? (rdata_ff | bit_m)
                                                      : (rdata_ff & ~bit_m);
            MODE_XOR:  mem[addr[IW-1:0]] <= rdata_ff ^ xmask;
            default:   mem[addr[IW-1:0]] <= color_ff ? BYTE_ONES : 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         done_ff     <= 1'b1;
      end else begin
         if (cmd.op == OP_RD) rd_valid_ff <= in_range;
         case (cmd.op)
            OP_LOAD: begin
               mode_ff      <= f_mode;
               color_ff     <= f_color;
               sbyte_ff     <= l_sbyte;
               col_ff       <= l_sbyte;
               ebyte_ff     <= l_ebyte;
               smask_ff     <= l_smask;
               emask_ff     <= l_emask;
               rows_left_ff <= l_nrows;
               px_ff        <= (POSX_W+SEGW)'(f_x);
               seg_left_ff  <= l_n;
               base_ff      <= (f_mode == MODE_FILL) ? '0
                               : AW'(32'(f_y) * 32'(rb));
               fill_end_ff  <= AW'(32'(rb) * 32'(rows));
               done_ff      <= (f_mode == MODE_XOR) ? l_done
                             : (f_mode == MODE_SEG) ? (l_n == '0)
                             : (f_mode == MODE_FILL) ? 1'b0 : 1'b0;
            end
            OP_NEXT: begin
               case (mode_ff)
                  MODE_XOR: begin
                     if (col_ff == ebyte_ff ||
                         (col_ff + CW'(1) == ebyte_ff && emask_ff == '0)) begin
                        col_ff       <= sbyte_ff;
                        base_ff      <= base_ff + AW'(rb);
                        rows_left_ff <= rows_left_ff - RW'(1);
                        if (rows_left_ff == RW'(1)) done_ff <= 1'b1;
                     end else begin
                        col_ff <= col_ff + CW'(1);
                     end
                  end
                  MODE_SEG: begin
                     px_ff       <= px_ff + (POSX_W+SEGW)'(1);
                     seg_left_ff <= seg_left_ff - SEGW'(1);
                     if (seg_left_ff == SEGW'(1)) done_ff <= 1'b1;
                  end
                  MODE_FILL: begin
                     base_ff <= base_ff + AW'(1);
                     if (base_ff + AW'(1) >= fill_end_ff ||
                         32'(base_ff) + 1 >= DEPTH) done_ff <= 1'b1;
                  end
                  default: done_ff <= 1'b1;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RD) bitsel_ff <= px_ff[2:0];
   end

   logic [7:0] rsel;
   assign rsel = rdata_ff & (BYTE_MSB >> bitsel_ff);

   always_comb begin
      sts.in_range   = in_range;
      sts.job_done   = done_ff;
      sts.is_read    = (mode_ff == MODE_GET) || (mode_ff == MODE_SEG);
      sts.pix        = rd_valid_ff && (rsel != '0);
      sts.final_item = (mode_ff == MODE_GET) || (seg_left_ff == SEGW'(1));
   end

endmodule

/* sv/mbro_ctrl.sv */
// Controller: sequences load, read, write and step commands; owns the result register.
// Depends on mbro_pkg.
`timescale 1ns / 1ps

module mbro_ctrl
   import mbro_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [MODE_W-1:0] req_mode,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output cmd_type           cmd,
   input  sts_type           sts
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_READ, S_USE, S_OUT, S_WAIT
   } state_type;

   state_type  state_ff, state_in;
   logic       vld_ff, vld_in;
   logic [1:0] dat_ff, dat_in;
   logic [MODE_W-1:0] mode_ff, mode_in;

   assign req_tready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {6'd0, dat_ff};

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff;
      dat_in   = dat_ff;
      mode_in  = mode_ff;
      cmd.op   = OP_NONE;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            cmd.op   = OP_LOAD;
            mode_in  = req_mode;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.job_done || !(mode_ff inside {MODE_PUT, MODE_GET, MODE_XOR,
                                                  MODE_SEG, MODE_FILL})) begin
               state_in = S_OUT;
            end else if (mode_ff == MODE_FILL) begin
               cmd.op   = OP_WR;
               state_in = S_USE;
            end else begin
               cmd.op   = OP_RD;
               state_in = S_USE;
            end
         end
         S_USE: begin
            if (sts.is_read) begin
               if (!vld_ff || rsp_tready) begin
                  vld_in = 1'b1;
                  dat_in = {sts.final_item, sts.pix};
                  cmd.op = OP_NEXT;
                  state_in = sts.final_item ? S_IDLE : S_CHECK;
               end
            end else begin
               if (mode_ff != MODE_FILL) cmd.op = OP_WR;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cmd.op = OP_NEXT;
            state_in = (mode_ff == MODE_PUT) ? S_OUT : S_CHECK;
         end
         S_OUT: if (!vld_ff || rsp_tready) begin
            vld_in   = 1'b1;
            dat_in   = 2'b10;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         dat_ff   <= '0;
         mode_ff  <= MODE_PUT;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         dat_ff   <= dat_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

/* sv/mono_bitmap_raster_ops_core.sv */
// One-bit-per-pixel frame store with dot, segment, rectangle-XOR and fill operations.
// Get dot reads the byte, then issues the result; put dot reads, then writes back; segment
// reads per pixel; rectangle reads then writes each byte, fill writes each (one read/write port).
// Throughput: one request at a time; the next is taken once the result is accepted.
// Reset (synchronous, high): registers return to row_bytes 64, image_rows 256; store
// contents stay undefined until written.
// Depends on mbro_pkg, mbro_ctrl, mbro_datapath.
`timescale 1ns / 1ps

module mono_bitmap_raster_ops_core
   import mbro_pkg::*;
#(
   parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int MAX_SEGMENT   = DEF_MAX_SEGMENT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode[2:0], pos_x[12:3], pos_y[20:13], span_width[30:21],
   // span_height[40:31], color[41], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel[0], last[1], zero fill above
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_data
);
   cmd_type cmd;
   sts_type sts;

   // controller: handshake, sequencing and the result register
   mbro_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tdata[MODE_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: registers, walker and byte store
   mbro_datapath #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_ROWS      (MAX_ROWS),
      .MAX_SEGMENT   (MAX_SEGMENT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* sv/mbro_checker.sv */
// Port-level checks for mono_bitmap_raster_ops_core, attached by bind.
// Depends on mbro_pkg.
`timescale 1ns / 1ps

module mbro_checker
   import mbro_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [7:0]            rsp_tdata
);
   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no new request while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   // no result in the cycle right after a request transfer
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result straight after request");

   // a request is never taken in two consecutive cycles
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");

   // fill bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'd0)
      else $error("result padding not zero");
endmodule

bind mono_bitmap_raster_ops_core mbro_checker u_mbro_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/testbench.sv */
// Self-checking bench for mono_bitmap_raster_ops_core: directed table then random requests
// per register setting, predicted by a local bit-accurate frame store. Depends on mbro_pkg.
`timescale 1ns / 1ps

module testbench
   import mbro_pkg::*;
;

   localparam int STORE_BYTES = DEF_MAX_ROW_BYTES * DEF_MAX_ROWS;

   typedef struct packed {
      logic             color;
      logic [SPAN_W-1:0] height;
      logic [SPAN_W-1:0] width;
      logic [POSY_W-1:0] py;
      logic [POSX_W-1:0] px;
      logic [MODE_W-1:0] mode;
   } raster_req_type;

   // one queued request; a typed-in answer overrides the frame predictor
   typedef struct {
      raster_req_type req;
      bit             typed;
      bit             typed_pix;
   } queued_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_ROW_BYTES;
   logic [CSR_W-1:0]      csr_data = '0;

   mono_bitmap_raster_ops_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // frame copy and register copy for prediction
   logic [7:0]          frame_bytes [STORE_BYTES];
   logic [RB_REG_W-1:0] stride_reg = 7'd64;
   logic [IR_REG_W-1:0] rows_reg   = 9'd256;

   queued_req_type pending_reqs[$];
   logic [1:0]     pixel_results[$];   // {last, pixel}
   queued_req_type offered;
   int             errors = 0;
   bit             idling_on = 1'b1;
   bit             long_hold = 1'b0;
   int             queued_before = 0;

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int eff_stride();
      if (stride_reg < 1) return 1;
      if (stride_reg > DEF_MAX_ROW_BYTES) return DEF_MAX_ROW_BYTES;
      return int'(stride_reg);
   endfunction

   function automatic int eff_rows();
      if (rows_reg < 1) return 1;
      if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic bit pixel_at(input int x, input int y, input int rb);
      int addr;
      addr = y * rb + (x >> 3);
      if (addr >= STORE_BYTES) return 1'b0;
      return frame_bytes[addr][7 - (x & 7)];
   endfunction

   function automatic void xor_into(input int addr, input logic [7:0] mask);
      if (addr < STORE_BYTES) frame_bytes[addr] = frame_bytes[addr] ^ mask;
   endfunction

   function automatic void invert_rect(input int x, input int y, input int w, input int h);
      int rb, rows, sbyte, ebyte, nrows;
      logic [7:0] smask, emask;
      rb = eff_stride();
      rows = eff_rows();
      sbyte = x >> 3;
      ebyte = (x + w) >> 3;
      smask = BYTE_ONES >> (x & 7);
      emask = ~(BYTE_ONES >> ((x + w) & 7));
      if (sbyte >= rb) return;
      if (sbyte == ebyte) smask &= emask;
      else if (ebyte >= rb) begin
         ebyte = rb;
         emask = 8'h00;
      end
      if (y >= rows) return;
      nrows = (h + y > rows) ? rows - y : h;
      for (int r = 0; r < nrows; r++) begin
         xor_into((y + r) * rb + sbyte, smask);
         for (int b = sbyte + 1; b < ebyte; b++) xor_into((y + r) * rb + b, BYTE_ONES);
         if (ebyte > sbyte && emask != 8'h00) xor_into((y + r) * rb + ebyte, emask);
      end
   endfunction

   // apply one request to the frame copy and queue the results it must give
   function automatic void predict_pixels(input raster_req_type r);
      int rb, n, addr, size;
      rb = eff_stride();
      case (r.mode)
         MODE_GET: pixel_results.push_back({1'b1, pixel_at(r.px, r.py, rb)});
         MODE_SEG: begin
            n = (r.width > DEF_MAX_SEGMENT) ? DEF_MAX_SEGMENT : int'(r.width);
            if (n == 0) pixel_results.push_back(2'b10);
            for (int i = 0; i < n; i++)
               pixel_results.push_back({i + 1 == n, pixel_at(r.px + i, r.py, rb)});
         end
         default: begin
            if (r.mode == MODE_PUT) begin
               addr = r.py * rb + (r.px >> 3);
               if (addr < STORE_BYTES) frame_bytes[addr][7 - (r.px & 7)] = r.color;
            end else if (r.mode == MODE_XOR) begin
               invert_rect(r.px, r.py, r.width, r.height);
            end else if (r.mode == MODE_FILL) begin
               size = rb * eff_rows();
               if (size > STORE_BYTES) size = STORE_BYTES;
               for (int i = 0; i < size; i++) frame_bytes[i] = r.color ? BYTE_ONES : 8'h00;
            end
            pixel_results.push_back(2'b10);
         end
      endcase
   endfunction

   // sender: predict on each accepted transfer, then hold, gap or offer the next
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered transfer
      end else begin
         if (req_tvalid) begin
            // advance the frame copy always; a typed-in answer replaces the predicted one
            queued_before = pixel_results.size();
            predict_pixels(offered.req);
            if (offered.typed) begin
               while (pixel_results.size() > queued_before) void'(pixel_results.pop_back());
               pixel_results.push_back({1'b1, offered.typed_pix});
            end
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0 && idling_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            offered = pending_reqs.pop_front();
            req_tdata <= REQ_DATA_W'(offered.req);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: check each result transfer, then stall in bursts or for a long hold-off
   int rsp_gap = 0;
   int hold_cycles = 0;
   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_results.size() == 0) begin
               report("unexpected result", int'(rsp_tdata), 0);
            end else begin
               want = pixel_results.pop_front();
               if (rsp_tdata[0] !== want[0])
                  report("pixel", int'(rsp_tdata[0]), int'(want[0]));
               if (rsp_tdata[1] !== want[1])
                  report("last", int'(rsp_tdata[1]), int'(want[1]));
            end
         end
         if (long_hold) begin
            long_hold = 1'b0;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic queued_req_type mk(input logic [MODE_W-1:0] mode, input int x,
                                         input int y, input int w, input int h,
                                         input bit color, input bit typed = 0,
                                         input bit typed_pix = 0);
      queued_req_type q;
      q.req = '{color: color, height: SPAN_W'(h), width: SPAN_W'(w), py: POSY_W'(y),
                px: POSX_W'(x), mode: mode};
      q.typed = typed;
      q.typed_pix = typed_pix;
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || pixel_results.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= CSR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_ROW_BYTES) stride_reg = RB_REG_W'(value);
      else rows_reg = IR_REG_W'(value);
   endtask

   function automatic queued_req_type random_req();
      int rb, rows, pick, x, y, w, h;
      logic [MODE_W-1:0] mode;
      rb = eff_stride();
      rows = eff_rows();
      pick = $urandom_range(0, 99);
      if (pick < 25) mode = MODE_PUT;
      else if (pick < 45) mode = MODE_GET;
      else if (pick < 65) mode = MODE_XOR;
      else if (pick < 90) mode = MODE_SEG;
      else if (pick < 94 && rb * rows <= 2048) mode = MODE_FILL;
      else mode = MODE_W'(32'(MODE_FILL) + $urandom_range(1, 3));   // unknown modes
      // mostly inside the image, now and then anywhere in the field range
      x = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, rb * 8 + 15);
      y = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                    : $urandom_range(0, rows + 1 > 255 ? 255 : rows + 1);
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 70);
      h = $urandom_range(0, 19) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 12);
      return mk(mode, x, y, w, h, $urandom_range(0, 1));
   endfunction

   queued_req_type directed_rows[] = '{
      mk(MODE_FILL, 0, 0, 0, 0, 1, 1, 0),           // whole store to ones first
      mk(MODE_GET, 0, 0, 0, 0, 0, 1, 1),
      mk(MODE_PUT, 0, 0, 0, 0, 0, 1, 0),
      mk(MODE_GET, 0, 0, 0, 0, 1, 1, 0),
      mk(MODE_GET, 1023, 255, 1023, 1023, 1, 1, 0), // beyond the store reads zero
      mk(MODE_PUT, 1023, 255, 0, 0, 1, 1, 0),       // beyond the store, dropped
      mk(MODE_SEG, 0, 0, 0, 0, 0, 1, 0),            // zero-width segment
      mk(MODE_SEG, 0, 0, 1023, 0, 0),               // saturates at full segment
      mk(MODE_XOR, 3, 0, 2, 1, 1),                  // both edges in one byte
      mk(MODE_XOR, 5, 1, 1023, 1023, 0),            // clipped right and bottom
      mk(MODE_XOR, 600, 2, 8, 4, 0, 1, 0),          // left edge past row end
      mk(MODE_XOR, 0, 255, 8, 0, 0, 1, 0),
      mk(3'd5, 0, 0, 0, 0, 0, 1, 0),
      mk(3'd6, 0, 0, 0, 0, 0, 1, 0),
      mk(3'd7, 1023, 255, 1023, 1023, 1, 1, 0),
      mk(MODE_PUT, 1023, 0, 0, 0, 1),               // reaches into the next row
      mk(MODE_SEG, 1000, 255, 64, 0, 0),            // runs off the store end
      mk(MODE_SEG, 1016, 0, 20, 0, 0),
      mk(MODE_GET, 7, 3, 0, 0, 0),
      mk(MODE_XOR, 0, 0, 0, 5, 0),
      mk(MODE_SEG, 0, 1, 40, 0, 1),
      mk(MODE_FILL, 0, 0, 0, 0, 0, 1, 0),
      mk(MODE_GET, 0, 0, 0, 0, 0, 1, 0)
   };

   // register settings per phase: stride, rows, random requests
   int phase_cfg[7][3] = '{
      '{1, 1, 30}, '{0, 0, 20}, '{8, 16, 50}, '{3, 9, 50},
      '{127, 511, 40}, '{17, 40, 50}, '{64, 256, 40}
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) pending_reqs.push_back(directed_rows[i]);
      wait_drained();
      foreach (phase_cfg[p]) begin
         write_reg(CSR_ROW_BYTES, phase_cfg[p][0]);
         write_reg(CSR_IMAGE_ROWS, phase_cfg[p][1]);
         if (p == 6) idling_on = 1'b0;           // final stretch runs flat out
         for (int i = 0; i < phase_cfg[p][2]; i++) pending_reqs.push_back(random_req());
         if (p == 2) begin
            repeat (40) @(posedge clock);
            long_hold = 1'b1;                    // stall results while requests keep coming
         end
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
sv/mbro_pkg.sv
sv/mbro_datapath.sv
sv/mbro_ctrl.sv
sv/mono_bitmap_raster_ops_core.sv
sv/mbro_checker.sv
bench/testbench.sv
